FILE: design/block_cache_tag_manager_unit_macros.svh
// assertion macros for the block cache tag manager checker
// expects clk and rst_n in the scope where a macro is used
`ifndef BLOCK_CACHE_TAG_MANAGER_UNIT_MACROS_SVH
`define BLOCK_CACHE_TAG_MANAGER_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define BCTM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define BCTM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bctm_pkg.sv
// shared types, widths and codes of the block cache tag manager
// no dependencies; imported by the scan unit, the top level and the checkers
`timescale 1ns / 1ps

package bctm_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SCAN_W  = IDX_W + 1;
    localparam int RC_W    = $clog2(ENTRIES + 1);

    // field widths
    localparam int ACT_W  = 3;
    localparam int TAG_W  = 48;
    localparam int LIM_W  = 5;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 4;
    localparam int RCL_W  = 5;
    localparam int CNT_W  = 16;
    localparam int TICK_W = 32;

    // stream beat widths
    localparam int IN_W   = ACT_W + TAG_W + LIM_W;
    localparam int OUT_F  = STAT_W + SLOT_W + TAG_W + RCL_W;
    localparam int OUT_W  = ((OUT_F + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - OUT_F;

    // action codes
    localparam logic [ACT_W-1:0] ACT_GET        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MARK_DIRTY = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITTEN    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INVALIDATE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RECLAIM    = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_HIT        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FREE       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CLEAN      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DIRTY      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL       = 3'd4;
    localparam logic [STAT_W-1:0] STAT_DONE       = 3'd5;
    localparam logic [STAT_W-1:0] STAT_NOT_CACHED = 3'd6;

    localparam logic [CNT_W-1:0]  COUNT_MAX = 16'hFFFF;
    localparam logic [RCL_W-1:0]  RCL_MAX   = 5'd31;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  count;
        logic              dirty;
        logic [TICK_W-1:0] last;
    } entry_t;

    // sequencer to scan unit
    typedef struct packed {
        logic              start;
        logic              proc;
        logic [IDX_W-1:0]  idx;
        logic              reclaim;
        logic [LIM_W-1:0]  limit;
        logic [TAG_W-1:0]  tag;
    } scan_ctrl_t;

    // scan unit findings after a full pass
    typedef struct packed {
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic [CNT_W-1:0]  hit_count;
        logic              hit_dirty;
        logic [TICK_W-1:0] hit_last;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              clean_found;
        logic [IDX_W-1:0]  clean_idx;
        logic              dirty_found;
        logic [IDX_W-1:0]  dirty_pick;
        logic [TAG_W-1:0]  dirty_tag;
        logic [RC_W-1:0]   rc_count;
    } scan_result_t;

endpackage

FILE: design/bctm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bctm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bctm_scan.sv
// scan unit: walks the table one entry per cycle and keeps the hit,
// the first free slot, the oldest clean and dirty victims and reclaims
// depends on bctm_pkg
`timescale 1ns / 1ps

module bctm_scan
    import bctm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  scan_ctrl_t   ctrl,
    input  logic         cur_valid,
    input  entry_t       cur_entry,
    output logic         reclaim_clr,
    output scan_result_t result
);

    // tracker flags
    logic hit_found_reg, hit_found_next;
    logic free_found_reg, free_found_next;
    logic clean_found_reg, clean_found_next;
    logic dirty_found_reg, dirty_found_next;
    logic [RC_W-1:0] rc_count_reg, rc_count_next;

    // tracker payload
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]  hit_count_reg, hit_count_next;
    logic              hit_dirty_reg, hit_dirty_next;
    logic [TICK_W-1:0] hit_last_reg, hit_last_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  clean_idx_reg, clean_idx_next;
    logic [TICK_W-1:0] clean_last_reg, clean_last_next;
    logic [IDX_W-1:0]  dirty_pick_reg, dirty_pick_next;
    logic [TICK_W-1:0] dirty_last_reg, dirty_last_next;
    logic [TAG_W-1:0]  dirty_tag_reg, dirty_tag_next;

    logic unref;
    logic limit_hit;

    assign unref     = cur_valid && (cur_entry.count == '0);
    assign limit_hit = (ctrl.limit != '0) && (32'(rc_count_reg) >= 32'(ctrl.limit));

    // per-entry update of the trackers
    always_comb
    begin
        hit_found_next   = hit_found_reg;
        free_found_next  = free_found_reg;
        clean_found_next = clean_found_reg;
        dirty_found_next = dirty_found_reg;
        rc_count_next    = rc_count_reg;
        hit_idx_next     = hit_idx_reg;
        hit_count_next   = hit_count_reg;
        hit_dirty_next   = hit_dirty_reg;
        hit_last_next    = hit_last_reg;
        free_idx_next    = free_idx_reg;
        clean_idx_next   = clean_idx_reg;
        clean_last_next  = clean_last_reg;
        dirty_pick_next  = dirty_pick_reg;
        dirty_last_next  = dirty_last_reg;
        dirty_tag_next   = dirty_tag_reg;
        reclaim_clr      = 1'b0;

        if (ctrl.start)
        begin
            hit_found_next   = 1'b0;
            free_found_next  = 1'b0;
            clean_found_next = 1'b0;
            dirty_found_next = 1'b0;
            rc_count_next    = '0;
        end
        else if (ctrl.proc)
        begin
            // first valid entry with a matching tag
            if (cur_valid && (cur_entry.tag == ctrl.tag) && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = ctrl.idx;
                hit_count_next = cur_entry.count;
                hit_dirty_next = cur_entry.dirty;
                hit_last_next  = cur_entry.last;
            end

            // first invalid entry ends the victim search
            if (!cur_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = ctrl.idx;
            end

            // oldest unreferenced entry, lowest index on a tie
            if (unref && !free_found_reg)
            begin
                if (cur_entry.dirty)
                begin
                    if (!dirty_found_reg || (cur_entry.last < dirty_last_reg))
                    begin
                        dirty_found_next = 1'b1;
                        dirty_pick_next  = ctrl.idx;
                        dirty_last_next  = cur_entry.last;
                        dirty_tag_next   = cur_entry.tag;
                    end
                end
                else
                begin
                    if (!clean_found_reg || (cur_entry.last < clean_last_reg))
                    begin
                        clean_found_next = 1'b1;
                        clean_idx_next   = ctrl.idx;
                        clean_last_next  = cur_entry.last;
                    end
                end
            end

            // reclaim clean unreferenced entries up to the limit
            if (ctrl.reclaim && unref && !cur_entry.dirty && !limit_hit)
            begin
                reclaim_clr   = 1'b1;
                rc_count_next = rc_count_reg + RC_W'(1);
            end
        end
    end

    // flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            clean_found_reg <= 1'b0;
            dirty_found_reg <= 1'b0;
            rc_count_reg    <= '0;
        end
        else
        begin
            hit_found_reg   <= hit_found_next;
            free_found_reg  <= free_found_next;
            clean_found_reg <= clean_found_next;
            dirty_found_reg <= dirty_found_next;
            rc_count_reg    <= rc_count_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        hit_idx_reg    <= hit_idx_next;
        hit_count_reg  <= hit_count_next;
        hit_dirty_reg  <= hit_dirty_next;
        hit_last_reg   <= hit_last_next;
        free_idx_reg   <= free_idx_next;
        clean_idx_reg  <= clean_idx_next;
        clean_last_reg <= clean_last_next;
        dirty_pick_reg <= dirty_pick_next;
        dirty_last_reg <= dirty_last_next;
        dirty_tag_reg  <= dirty_tag_next;
    end

    assign result.hit_found   = hit_found_reg;
    assign result.hit_idx     = hit_idx_reg;
    assign result.hit_count   = hit_count_reg;
    assign result.hit_dirty   = hit_dirty_reg;
    assign result.hit_last    = hit_last_reg;
    assign result.free_found  = free_found_reg;
    assign result.free_idx    = free_idx_reg;
    assign result.clean_found = clean_found_reg;
    assign result.clean_idx   = clean_idx_reg;
    assign result.dirty_found = dirty_found_reg;
    assign result.dirty_pick  = dirty_pick_reg;
    assign result.dirty_tag   = dirty_tag_reg;
    assign result.rc_count    = rc_count_reg;

endmodule

FILE: design/block_cache_tag_manager_unit.sv
// channel  | dir | beat contents (lowest bits first)
// s_axis   | in  | action[2:0], block_number[50:3], reclaim_limit[55:51]
// m_axis   | out | status[2:0], slot[6:3], evicted_block[54:7],
//          |     | reclaimed_count[59:55], zero pad[63:60]
// for each beat the table ram is read one entry per cycle, then the finish state decides
// and writes the entry back
// reset clears the valid bits and the access tick; entries are never swept
// a waiting result stays in the output register while the next beat is taken;
// the write-back cycle holds until that result leaves
// top level: sequencer, valid bits, access tick and result register
// depends on bctm_pkg, bctm_ram and bctm_scan
`timescale 1ns / 1ps

module block_cache_tag_manager_unit
    import bctm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // action, block_number, reclaim_limit
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // status, slot, evicted_block, reclaimed_count
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [SCAN_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic               proc_reg, proc_next;
    logic [IDX_W-1:0]   proc_idx_reg, proc_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic [ACT_W-1:0]   act_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [LIM_W-1:0]   limit_reg;

    logic               s_fire;
    logic               rd_more;
    logic               commit;
    logic               ram_re;
    logic               ram_we;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_entry;
    entry_t             rd_entry;
    scan_ctrl_t         scan_ctrl;
    scan_result_t       scan_res;
    logic               reclaim_clr;
    logic [TICK_W-1:0]  tick_inc;

    logic [STAT_W-1:0]  res_status;
    logic [IDX_W-1:0]   res_idx;
    logic [TAG_W-1:0]   res_evict;
    logic [RCL_W-1:0]   res_rcl;
    logic               res_set_valid;
    logic               res_clr_valid;
    logic               res_bump;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign rd_more       = (rd_cnt_reg < SCAN_W'(ENTRIES));
    assign commit        = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);
    assign ram_re        = (state_reg == ST_SCAN) && rd_more;
    assign tick_inc      = tick_reg + TICK_W'(1);

    // entry table
    bctm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // scan control
    assign scan_ctrl.start   = s_fire;
    assign scan_ctrl.proc    = proc_reg;
    assign scan_ctrl.idx     = proc_idx_reg;
    assign scan_ctrl.reclaim = (act_reg == ACT_RECLAIM);
    assign scan_ctrl.limit   = limit_reg;
    assign scan_ctrl.tag     = tag_reg;

    bctm_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (scan_ctrl),
        .cur_valid   (valid_reg[proc_idx_reg]),
        .cur_entry   (rd_entry),
        .reclaim_clr (reclaim_clr),
        .result      (scan_res)
    );

    // decision after the scan
    always_comb
    begin
        res_status    = STAT_DONE;
        res_idx       = '0;
        res_evict     = '0;
        res_rcl       = '0;
        res_set_valid = 1'b0;
        res_clr_valid = 1'b0;
        res_bump      = 1'b0;
        ram_we        = 1'b0;
        wr_idx        = scan_res.hit_idx;
        wr_entry.tag   = tag_reg;
        wr_entry.count = scan_res.hit_count;
        wr_entry.dirty = scan_res.hit_dirty;
        wr_entry.last  = scan_res.hit_last;

        unique case (act_reg)
            ACT_GET:
            begin
                if (scan_res.hit_found)
                begin
                    res_status = STAT_HIT;
                    res_idx    = scan_res.hit_idx;
                    res_bump   = 1'b1;
                    ram_we     = 1'b1;
                    if (scan_res.hit_count != COUNT_MAX)
                    begin
                        wr_entry.count = scan_res.hit_count + CNT_W'(1);
                    end
                    wr_entry.last = tick_inc;
                end
                else if (scan_res.free_found || scan_res.clean_found
                         || scan_res.dirty_found)
                begin
                    if (scan_res.free_found)
                    begin
                        res_status = STAT_FREE;
                        res_idx    = scan_res.free_idx;
                    end
                    else if (scan_res.clean_found)
                    begin
                        res_status = STAT_CLEAN;
                        res_idx    = scan_res.clean_idx;
                    end
                    else
                    begin
                        res_status = STAT_DIRTY;
                        res_idx    = scan_res.dirty_pick;
                        res_evict  = scan_res.dirty_tag;
                    end
                    res_set_valid  = 1'b1;
                    res_bump       = 1'b1;
                    ram_we         = 1'b1;
                    wr_idx         = res_idx;
                    wr_entry.count = CNT_W'(1);
                    wr_entry.dirty = 1'b0;
                    wr_entry.last  = tick_inc;
                end
                else
                begin
                    res_status = STAT_FULL;
                end
            end
            ACT_RELEASE, ACT_MARK_DIRTY, ACT_WRITTEN, ACT_INVALIDATE:
            begin
                if (!scan_res.hit_found)
                begin
                    res_status = STAT_NOT_CACHED;
                end
                else
                begin
                    res_status = STAT_DONE;
                    res_idx    = scan_res.hit_idx;
                    if (act_reg == ACT_RELEASE)
                    begin
                        ram_we = 1'b1;
                        if (scan_res.hit_count != '0)
                        begin
                            wr_entry.count = scan_res.hit_count - CNT_W'(1);
                        end
                    end
                    else if (act_reg == ACT_MARK_DIRTY)
                    begin
                        ram_we         = 1'b1;
                        wr_entry.dirty = 1'b1;
                    end
                    else if (act_reg == ACT_WRITTEN)
                    begin
                        ram_we         = 1'b1;
                        res_bump       = 1'b1;
                        wr_entry.dirty = 1'b0;
                        wr_entry.last  = tick_inc;
                    end
                    else
                    begin
                        res_clr_valid = 1'b1;
                    end
                end
            end
            ACT_RECLAIM:
            begin
                if (32'(scan_res.rc_count) > 32'(RCL_MAX))
                begin
                    res_rcl = RCL_MAX;
                end
                else
                begin
                    res_rcl = RCL_W'(scan_res.rc_count);
                end
            end
            default:
            begin
                res_status = STAT_DONE;
            end
        endcase

        ram_we = ram_we && commit;
    end

    // sequencer and state updates
    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        proc_next      = 1'b0;
        proc_idx_next  = proc_idx_reg;
        valid_next     = valid_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // reclaim clears entries as the scan passes them
        if (reclaim_clr)
        begin
            valid_next[proc_idx_reg] = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_more)
                begin
                    proc_next     = 1'b1;
                    proc_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + SCAN_W'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    if (res_set_valid)
                    begin
                        valid_next[res_idx] = 1'b1;
                    end
                    if (res_clr_valid)
                    begin
                        valid_next[res_idx] = 1'b0;
                    end
                    if (res_bump)
                    begin
                        tick_next = tick_inc;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, res_rcl, res_evict,
                                      SLOT_W'(res_idx), res_status};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            proc_reg      <= 1'b0;
            valid_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            proc_reg      <= proc_next;
            valid_reg     <= valid_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        out_data_reg <= out_data_next;
        if (s_fire)
        begin
            act_reg   <= s_axis_tdata[ACT_W-1:0];
            tag_reg   <= s_axis_tdata[ACT_W +: TAG_W];
            limit_reg <= s_axis_tdata[ACT_W+TAG_W +: LIM_W];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: design/bctm_checker.sv
// port-level checker for the block cache tag manager, bound to the top level
// depends on bctm_pkg and block_cache_tag_manager_unit_macros.svh
`timescale 1ns / 1ps
`include "block_cache_tag_manager_unit_macros.svh"

module bctm_checker
    import bctm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,  // action, block_number, reclaim_limit
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata   // status, slot, evicted_block, reclaimed_count
);

    logic             s_fire;
    logic [STAT_W-1:0] out_status;
    logic [TAG_W-1:0]  out_evict;
    logic [RCL_W-1:0]  out_rcl;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign out_status = m_axis_tdata[STAT_W-1:0];
    assign out_evict  = m_axis_tdata[STAT_W+SLOT_W +: TAG_W];
    assign out_rcl    = m_axis_tdata[STAT_W+SLOT_W+TAG_W +: RCL_W];

    // a stalled result beat holds
    `BCTM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // one request at a time: no beat is taken right after another
    `BCTM_ASSERT_NEXT(a_one_at_a_time, s_fire, !s_axis_tready, "input taken while a request is in work")

    // an evicted tag only comes with a dirty victim
    `BCTM_ASSERT_NOW(a_evict_dirty, m_axis_tvalid && (out_status != STAT_DIRTY), out_evict == '0, "evicted tag without dirty victim")

    // a reclaim count only comes with a done status
    `BCTM_ASSERT_NOW(a_rcl_done, m_axis_tvalid && (out_rcl != '0), out_status == STAT_DONE, "reclaim count with wrong status")

endmodule

bind block_cache_tag_manager_unit bctm_checker u_bctm_checker (.*);

FILE: sim/bctm_checker.sv
// result checker for the block cache tag manager: keeps a shadow of the tag table,
// predicts one result beat per request beat and compares the two streams in order
// depends on bctm_pkg
`timescale 1ns / 1ps

module bctm_result_checker
    import bctm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // action, block_number, reclaim_limit
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,  // status, slot, evicted_block, reclaimed_count
    output int               mismatches,
    output int               open_answers
);

    // result beat field offsets
    localparam int SLOT_LSB  = STAT_W;
    localparam int EVICT_LSB = STAT_W + SLOT_W;
    localparam int RCL_LSB   = EVICT_LSB + TAG_W;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  evicted;
        logic [RCL_W-1:0]  reclaimed;
    } answer_t;

    // shadow of the tag table
    logic              line_valid [ENTRIES];
    logic [TAG_W-1:0]  line_tag   [ENTRIES];
    logic [CNT_W-1:0]  line_refs  [ENTRIES];
    logic              line_dirty [ENTRIES];
    logic [TICK_W-1:0] line_stamp [ENTRIES];
    logic [TICK_W-1:0] stamp_now;

    answer_t due_answers [$];
    answer_t want;
    int      fail_n = 0;

    function automatic int find_line(input logic [TAG_W-1:0] blk);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (line_valid[i] && line_tag[i] == blk)
                return i;
        end
        return -1;
    endfunction

    task automatic stamp_line(input int i);
        stamp_now     = stamp_now + 1'b1;
        line_stamp[i] = stamp_now;
    endtask

    task automatic clear_line(input int i);
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_refs[i]  = '0;
        line_dirty[i] = 1'b0;
        line_stamp[i] = '0;
    endtask

    // one request against the shadow table
    task automatic run_cache_action(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] blk,
                                    input logic [LIM_W-1:0] lim, output answer_t ans);
        int hit;
        int free_i;
        int clean_i;
        int dirty_i;
        int pick;
        int taken;
        ans        = '0;
        ans.status = STAT_DONE;
        hit        = find_line(blk);
        case (act)
            ACT_GET:
            begin
                if (hit >= 0)
                begin
                    if (line_refs[hit] != COUNT_MAX)
                        line_refs[hit] = line_refs[hit] + 1'b1;
                    stamp_line(hit);
                    ans.status = STAT_HIT;
                    ans.slot   = SLOT_W'(hit);
                end
                else
                begin
                    free_i  = -1;
                    clean_i = -1;
                    dirty_i = -1;
                    // first free line, else oldest unreferenced clean, else oldest dirty
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!line_valid[i])
                        begin
                            free_i = i;
                            break;
                        end
                        if (line_refs[i] == '0)
                        begin
                            if (line_dirty[i])
                            begin
                                if (dirty_i < 0 || line_stamp[i] < line_stamp[dirty_i])
                                    dirty_i = i;
                            end
                            else if (clean_i < 0 || line_stamp[i] < line_stamp[clean_i])
                                clean_i = i;
                        end
                    end
                    pick = -1;
                    if (free_i >= 0)
                    begin
                        pick       = free_i;
                        ans.status = STAT_FREE;
                    end
                    else if (clean_i >= 0)
                    begin
                        pick       = clean_i;
                        ans.status = STAT_CLEAN;
                    end
                    else if (dirty_i >= 0)
                    begin
                        pick        = dirty_i;
                        ans.status  = STAT_DIRTY;
                        ans.evicted = line_tag[dirty_i];
                    end
                    else
                        ans.status = STAT_FULL;
                    // allocate the chosen line
                    if (pick >= 0)
                    begin
                        line_valid[pick] = 1'b1;
                        line_tag[pick]   = blk;
                        line_refs[pick]  = CNT_W'(1);
                        line_dirty[pick] = 1'b0;
                        stamp_line(pick);
                        ans.slot = SLOT_W'(pick);
                    end
                end
            end
            ACT_RELEASE, ACT_MARK_DIRTY, ACT_WRITTEN, ACT_INVALIDATE:
            begin
                if (hit < 0)
                    ans.status = STAT_NOT_CACHED;
                else
                begin
                    ans.slot = SLOT_W'(hit);
                    case (act)
                        ACT_RELEASE:
                        begin
                            if (line_refs[hit] != '0)
                                line_refs[hit] = line_refs[hit] - 1'b1;
                        end
                        ACT_MARK_DIRTY:
                            line_dirty[hit] = 1'b1;
                        ACT_WRITTEN:
                        begin
                            line_dirty[hit] = 1'b0;
                            stamp_line(hit);
                        end
                        default:
                            clear_line(hit);
                    endcase
                end
            end
            ACT_RECLAIM:
            begin
                // drop clean unreferenced lines in index order up to the limit
                taken = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (lim != '0 && taken >= lim)
                        break;
                    if (line_valid[i] && line_refs[i] == '0 && !line_dirty[i])
                    begin
                        clear_line(i);
                        taken++;
                    end
                end
                ans.reclaimed = (taken > RCL_MAX) ? RCL_MAX : RCL_W'(taken);
            end
            default:
            begin
                // spare action codes leave the table alone
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [TAG_W-1:0] exp_v,
                               input logic [TAG_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_n++;
        end
    endtask

    // watch both channels; the result side goes first so a beat never meets its own request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                clear_line(i);
            stamp_now = '0;
            due_answers.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_answers.size() == 0)
                begin
                    $error("result beat with no request outstanding: 0x%0h", m_axis_tdata);
                    fail_n++;
                end
                else
                begin
                    want = due_answers.pop_front();
                    check_field("status", TAG_W'(want.status),
                                TAG_W'(m_axis_tdata[STAT_W-1:0]));
                    check_field("slot", TAG_W'(want.slot),
                                TAG_W'(m_axis_tdata[SLOT_LSB +: SLOT_W]));
                    check_field("evicted_block", want.evicted,
                                m_axis_tdata[EVICT_LSB +: TAG_W]);
                    check_field("reclaimed_count", TAG_W'(want.reclaimed),
                                TAG_W'(m_axis_tdata[RCL_LSB +: RCL_W]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                run_cache_action(s_axis_tdata[ACT_W-1:0], s_axis_tdata[ACT_W +: TAG_W],
                                 s_axis_tdata[ACT_W + TAG_W +: LIM_W], want);
                due_answers.push_back(want);
            end
        end
        mismatches   <= fail_n;
        open_answers <= due_answers.size();
    end

endmodule

FILE: sim/tb_top.sv
// top of the block cache tag manager testbench: clock, reset, request and result
// traffic with random gaps and stalls, and the verdict
// depends on bctm_pkg, block_cache_tag_manager_unit and bctm_result_checker
`timescale 1ns / 1ps

module tb_top;
    import bctm_pkg::*;

    // action codes the block treats as no-ops
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam logic [TAG_W-1:0] TAG_ONES     = '1;
    localparam int               POOL_N       = 24;
    localparam int               RANDOM_BEATS = 650;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;   // action, block_number, reclaim_limit
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // status, slot, evicted_block, reclaimed_count

    int mismatches;
    int open_answers;

    logic [TAG_W-1:0] tag_pool [POOL_N];
    int               burst_left = 0;
    int               rx_mode = 0;
    int               rx_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    block_cache_tag_manager_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bctm_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .open_answers  (open_answers)
    );

    // result side: long ready runs, coin-flip runs and solid stalls
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = (rx_mode == 2) ? $urandom_range(1, 20) : $urandom_range(10, 120);
        end
        else
            rx_left--;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= 1'b0;
        endcase
    end

    // one request beat, opening a new burst, mostly after a random gap, when the last one ran out
    task automatic send(input logic [ACT_W-1:0] act, input logic [TAG_W-1:0] blk,
                        input logic [LIM_W-1:0] lim);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tdata  <= {lim, blk, act};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [ACT_W-1:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 38)
            return ACT_GET;
        if (roll < 62)
            return ACT_RELEASE;
        if (roll < 72)
            return ACT_MARK_DIRTY;
        if (roll < 80)
            return ACT_WRITTEN;
        if (roll < 87)
            return ACT_INVALIDATE;
        if (roll < 95)
            return ACT_RECLAIM;
        if (roll < 97)
            return ACT_SPARE_LO;
        return ACT_SPARE_HI;
    endfunction

    initial
    begin
        logic [63:0]      wide;
        logic [TAG_W-1:0] blk;

        // small set of block numbers so hits and evictions are common
        for (int i = 0; i < POOL_N; i++)
        begin
            wide        = {$urandom, $urandom};
            tag_pool[i] = (i < 8) ? TAG_W'(i * 3) : wide[TAG_W-1:0];
        end
        tag_pool[1] = TAG_ONES;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // lookups on an empty table
        send(ACT_RELEASE, '0, '0);
        send(ACT_INVALIDATE, TAG_ONES, '0);
        send(ACT_RECLAIM, '0, '0);
        // fill every line, lowest and highest block number included
        send(ACT_GET, '0, '0);
        send(ACT_GET, TAG_ONES, '0);
        for (int i = 2; i < ENTRIES; i++)
            send(ACT_GET, TAG_W'(i), '0);
        // all lines referenced: full, mark and write-back of an uncached block, then a hit and release past zero
        send(ACT_GET, TAG_W'(ENTRIES), '0);
        send(ACT_MARK_DIRTY, TAG_W'(ENTRIES), '0);
        send(ACT_WRITTEN, TAG_W'(ENTRIES), '0);
        send(ACT_GET, '0, '0);
        repeat (3) send(ACT_RELEASE, '0, '0);
        // clean victim preferred over a newer dirty one, then the dirty victim
        send(ACT_MARK_DIRTY, '0, '0);
        send(ACT_RELEASE, TAG_ONES, '0);
        send(ACT_GET, TAG_W'(17), '0);
        send(ACT_GET, TAG_W'(18), '0);
        send(ACT_WRITTEN, TAG_W'(18), '0);
        send(ACT_MARK_DIRTY, TAG_W'(5), '0);
        send(ACT_WRITTEN, TAG_W'(5), '0);
        // invalidate frees a referenced line
        send(ACT_INVALIDATE, TAG_W'(3), '0);
        send(ACT_GET, TAG_W'(19), '0);
        // reclaim with a limit, a limit past the table size and no limit
        for (int i = 4; i < 10; i++)
            send(ACT_RELEASE, TAG_W'(i), '0);
        send(ACT_MARK_DIRTY, TAG_W'(8), '0);
        send(ACT_RECLAIM, '0, 5'd2);
        send(ACT_RECLAIM, TAG_ONES, 5'd31);
        send(ACT_RECLAIM, '0, 5'd16);
        send(ACT_RECLAIM, '0, '0);
        send(ACT_SPARE_LO, TAG_ONES, 5'd31);
        send(ACT_SPARE_HI, '0, '0);

        // random traffic, mostly on the pool with some arbitrary block numbers
        repeat (RANDOM_BEATS)
        begin
            wide = {$urandom, $urandom};
            blk  = ($urandom_range(0, 9) == 0) ? wide[TAG_W-1:0]
                                                : tag_pool[$urandom_range(0, POOL_N - 1)];
            send(pick_action(), blk, LIM_W'($urandom_range(0, 31)));
        end
        s_axis_tvalid <= 1'b0;

        // drain, then wait for anything stray
        do
            @(posedge clk);
        while (open_answers != 0);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
